// ===== rtl/i2cm_pkg.sv =====
// Shared types for the I2C master byte engine.
`default_nettype none
package i2cm_pkg;

  typedef enum logic [2:0] {
    CMD_IDLE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4
  } cmd_e;

  localparam logic [15:0] HalfReset = 16'd30;
  // last phase group of a byte command (ack clock)
  localparam logic [3:0] LastGrp = 4'd8;

  // engine state; phase index = grp * 3 + sub
  typedef struct packed {
    cmd_e        cmd;
    logic [3:0]  grp;
    logic [1:0]  sub;
    logic [15:0] tick;
    logic [7:0]  shift;
    logic        ack_to_send;
    logic        scl;
    logic        sda;
    logic        ack_flag;
    logic [7:0]  read_result;
  } state_t;

  typedef struct packed {
    logic       scl_pull_low;
    logic       sda_pull_low;
    logic       busy_res;
    logic       done_res;
    logic       ack_received;
    logic [7:0] read_byte;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/i2cm_step.sv =====
// Next-state and per-tick result logic of the I2C master byte engine.
`default_nettype none
module i2cm_step (
  input  var i2cm_pkg::state_t state_i,
  input  wire logic [15:0]     half_i,
  input  wire logic [2:0]      opcode_i,
  input  wire logic [7:0]      write_byte_i,
  input  wire logic            send_ack_i,
  input  wire logic            sda_level_i,
  output i2cm_pkg::state_t     state_o,
  output i2cm_pkg::res_t       res_o
);

  // line drives on entering a phase: returns {scl, sda}
  function automatic logic [1:0] enter_phase(input i2cm_pkg::cmd_e cmd,
                                             input logic [3:0] grp,
                                             input logic [1:0] sub,
                                             input logic [7:0] shift,
                                             input logic ack_to_send,
                                             input logic scl,
                                             input logic sda);
    logic s_scl;
    logic s_sda;
    s_scl = scl;
    s_sda = sda;
    unique case (cmd)
      i2cm_pkg::CMD_START: begin
        if (sub == 2'd0) begin
          s_sda = 1'b0;
          s_scl = 1'b0;
        end else if (sub == 2'd1) s_sda = 1'b1;
        else s_scl = 1'b1;
      end
      i2cm_pkg::CMD_STOP: begin
        if (sub == 2'd0) s_sda = 1'b1;
        else if (sub == 2'd1) s_scl = 1'b0;
        else s_sda = 1'b0;
      end
      i2cm_pkg::CMD_WRITE, i2cm_pkg::CMD_READ: begin
        if (sub == 2'd0) begin
          if (grp == i2cm_pkg::LastGrp) begin
            s_sda = (cmd == i2cm_pkg::CMD_READ) ? ack_to_send : 1'b0;
          end else if (cmd == i2cm_pkg::CMD_WRITE) begin
            s_sda = ~shift[~grp[2:0]];   // MSB first
          end else if (grp == 4'd0) begin
            s_sda = 1'b0;
          end
        end else if (sub == 2'd1) s_scl = 1'b0;
        else s_scl = 1'b1;
      end
      default: ;
    endcase
    return {s_scl, s_sda};
  endfunction

  logic [15:0]      half_eff;
  logic [15:0]      tick_inc;
  logic             is_byte_cmd;
  logic             last_phase;
  logic             scl_out;
  logic             sda_out;
  logic             done;
  i2cm_pkg::state_t s;

  assign half_eff = (half_i == 16'd0) ? 16'd1 : half_i;

  always_comb begin
    s = state_i;
    done = 1'b0;

    if (s.cmd == i2cm_pkg::CMD_IDLE &&
        (opcode_i == i2cm_pkg::CMD_START || opcode_i == i2cm_pkg::CMD_STOP ||
         opcode_i == i2cm_pkg::CMD_WRITE || opcode_i == i2cm_pkg::CMD_READ)) begin
      s.cmd  = i2cm_pkg::cmd_e'(opcode_i);
      s.grp  = 4'd0;
      s.sub  = 2'd0;
      s.tick = 16'd0;
      if (opcode_i == i2cm_pkg::CMD_WRITE) s.shift = write_byte_i;
      else if (opcode_i == i2cm_pkg::CMD_READ) begin
        s.shift       = 8'd0;
        s.ack_to_send = send_ack_i;
      end
      {s.scl, s.sda} = enter_phase(s.cmd, s.grp, s.sub, s.shift, s.ack_to_send,
                                   s.scl, s.sda);
    end

    scl_out = s.scl;
    sda_out = s.sda;

    is_byte_cmd = (s.cmd == i2cm_pkg::CMD_WRITE) || (s.cmd == i2cm_pkg::CMD_READ);
    last_phase  = (s.sub == 2'd2) && (s.grp == (is_byte_cmd ? i2cm_pkg::LastGrp : 4'd0));
    tick_inc    = s.tick + 16'd1;

    if (s.cmd != i2cm_pkg::CMD_IDLE) begin
      s.tick = tick_inc;
      if (tick_inc >= half_eff) begin
        // sample on the last tick of the SCL-high data/ack phase
        if (s.sub == 2'd1) begin
          if (s.cmd == i2cm_pkg::CMD_WRITE && s.grp == i2cm_pkg::LastGrp) begin
            s.ack_flag = ~sda_level_i;
          end else if (s.cmd == i2cm_pkg::CMD_READ && s.grp < i2cm_pkg::LastGrp) begin
            s.shift[~s.grp[2:0]] = sda_level_i;
          end
        end
        s.tick = 16'd0;
        if (last_phase) begin
          if (s.cmd == i2cm_pkg::CMD_READ) begin
            s.sda         = 1'b0;
            s.read_result = s.shift;
          end
          s.cmd = i2cm_pkg::CMD_IDLE;
          s.grp = 4'd0;
          s.sub = 2'd0;
          done  = 1'b1;
        end else begin
          if (s.sub == 2'd2) begin
            s.sub = 2'd0;
            s.grp = s.grp + 4'd1;
          end else begin
            s.sub = s.sub + 2'd1;
          end
          {s.scl, s.sda} = enter_phase(s.cmd, s.grp, s.sub, s.shift, s.ack_to_send,
                                       s.scl, s.sda);
        end
      end
    end
  end

  assign state_o = s;

  always_comb begin
    res_o.scl_pull_low = scl_out;
    res_o.sda_pull_low = sda_out;
    res_o.busy_res     = (s.cmd != i2cm_pkg::CMD_IDLE);
    res_o.done_res     = done;
    res_o.ack_received = s.ack_flag;
    res_o.read_byte    = s.read_result;
  end

endmodule
`default_nettype wire

// ===== rtl/i2c_master_byte_engine_core.sv =====
// Top level of the I2C master byte engine: state, config and result registers.
`default_nettype none
// Each accepted item is one bus tick and yields exactly one result item in the
// next cycle. Throughput is one item per clock: the engine state advances in a
// single combinational pass between the state register and the result register,
// and a new item is taken whenever the result register is empty or being
// drained in the same cycle. START and STOP last 3 phases, WRITE and READ 27,
// each phase half_period_ticks items long (0 counts as 1). Commands arriving
// while busy are dropped. The half period register is written via cfg_we_i.
module i2c_master_byte_engine_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  opcode_i,
  input  wire logic [7:0]  write_byte_i,
  input  wire logic        send_ack_i,
  input  wire logic        sda_level_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             scl_pull_low_o,
  output logic             sda_pull_low_o,
  output logic             busy_res_o,
  output logic             done_res_o,
  output logic             ack_received_o,
  output logic [7:0]       read_byte_o
);

  logic [15:0]      half_q;
  i2cm_pkg::state_t state_q;
  i2cm_pkg::state_t state_d;
  i2cm_pkg::res_t   res_d;
  i2cm_pkg::res_t   res_q;
  logic             out_valid_q;
  logic             in_accept;

  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign in_accept  = in_valid_i & in_ready_o;

  i2cm_step u_step (
    .state_i      (state_q),
    .half_i       (half_q),
    .opcode_i     (opcode_i),
    .write_byte_i (write_byte_i),
    .send_ack_i   (send_ack_i),
    .sda_level_i  (sda_level_i),
    .state_o      (state_d),
    .res_o        (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= i2cm_pkg::HalfReset;
    end else if (cfg_we_i) begin
      half_q <= cfg_wdata_i;
    end
  end

  // all-zero state is the idle engine
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q             <= '0;
      out_valid_q         <= 1'b0;
    end else begin
      if (in_accept) state_q <= state_d;
      if (in_accept) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) res_q <= res_d;
  end

  assign out_valid_o    = out_valid_q;
  assign scl_pull_low_o = res_q.scl_pull_low;
  assign sda_pull_low_o = res_q.sda_pull_low;
  assign busy_res_o     = res_q.busy_res;
  assign done_res_o     = res_q.done_res;
  assign ack_received_o = res_q.ack_received;
  assign read_byte_o    = res_q.read_byte;

`ifndef SYNTHESIS
  // a completing item never reports busy
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !busy_res_o)
    else $error("done with busy set");

  // idle engine sits at phase zero
  a_idle_phase0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.cmd == i2cm_pkg::CMD_IDLE |-> state_q.grp == 4'd0 && state_q.sub == 2'd0)
    else $error("idle with nonzero phase");

  // phase counters stay within the 27-phase frame
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.grp <= i2cm_pkg::LastGrp && state_q.sub != 2'd3)
    else $error("phase out of range");

  // an accepted item always shows up as a result next cycle
  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> out_valid_o)
    else $error("item accepted without result");
`endif

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the I2C master byte engine: tick predictor, scoreboard and drivers.
module tb;

  // phase layout of the byte commands
  localparam int unsigned CondPhases    = 3;
  localparam int unsigned ByteCmdPhases = 27;
  localparam int unsigned DataPhases    = 24;
  localparam int unsigned AckSdaPhase   = 24;
  localparam int unsigned AckSclHigh    = 25;

  // opcodes with no command behind them
  localparam logic [2:0] OpSpareLo = 3'd5;
  localparam logic [2:0] OpSpareHi = 3'd7;

  // how SDA is sampled while a command runs
  localparam int LvLow  = 0;
  localparam int LvHigh = 1;
  localparam int LvRand = 2;

  localparam int TargetItems = 1300;
  localparam int CalmFrom    = 1100;

  class i2c_tick_scoreboard;
    logic [15:0]       half_period;
    i2cm_pkg::cmd_e    cmd;
    int unsigned       phase_no;
    logic [15:0]       tick_cnt;
    logic [7:0]        shift_reg;
    logic              ack_to_send;
    logic              scl_low;
    logic              sda_low;
    logic              ack_flag;
    logic [7:0]        read_result;
    i2cm_pkg::res_t    expected_q[$];
    int                errors;
    int                ticks;
    int                completions;
    int                acks_seen;
    int                started[5];

    function new();
      half_period = i2cm_pkg::HalfReset;
      cmd         = i2cm_pkg::CMD_IDLE;
      phase_no    = 0;
      tick_cnt    = '0;
      shift_reg   = '0;
      ack_to_send = 1'b0;
      scl_low     = 1'b0;
      sda_low     = 1'b0;
      ack_flag    = 1'b0;
      read_result = '0;
      errors      = 0;
      ticks       = 0;
      completions = 0;
      acks_seen   = 0;
      foreach (started[i]) started[i] = 0;
    endfunction

    function void set_half(logic [15:0] v);
      half_period = v;
    endfunction

    function bit busy();
      return cmd != i2cm_pkg::CMD_IDLE;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // line drives applied on entry to phase p
    function void enter_phase(int unsigned p);
      int unsigned sub;
      sub = p % 3;
      case (cmd)
        i2cm_pkg::CMD_START: begin
          if (p == 0) begin
            sda_low = 1'b0;
            scl_low = 1'b0;
          end else if (p == 1) sda_low = 1'b1;
          else scl_low = 1'b1;
        end
        i2cm_pkg::CMD_STOP: begin
          if (p == 0) sda_low = 1'b1;
          else if (p == 1) scl_low = 1'b0;
          else sda_low = 1'b0;
        end
        i2cm_pkg::CMD_WRITE: begin
          if (p < DataPhases) begin
            if (sub == 0) sda_low = ~shift_reg[7 - p / 3];
            else if (sub == 1) scl_low = 1'b0;
            else scl_low = 1'b1;
          end else if (p == AckSdaPhase) sda_low = 1'b0;
          else if (p == AckSclHigh) scl_low = 1'b0;
          else scl_low = 1'b1;
        end
        i2cm_pkg::CMD_READ: begin
          if (p < DataPhases) begin
            if (sub == 0) begin
              if (p == 0) sda_low = 1'b0;
            end else if (sub == 1) scl_low = 1'b0;
            else scl_low = 1'b1;
          end else if (p == AckSdaPhase) sda_low = ack_to_send;
          else if (p == AckSclHigh) scl_low = 1'b0;
          else scl_low = 1'b1;
        end
        default: ;
      endcase
    endfunction

    function void note_tick(logic [2:0] op, logic [7:0] wb, logic sa, logic lv);
      logic [15:0]    hp;
      int unsigned    total;
      i2cm_pkg::res_t r;
      logic           done;
      hp   = (half_period == '0) ? 16'd1 : half_period;
      done = 1'b0;
      if (cmd == i2cm_pkg::CMD_IDLE && op >= i2cm_pkg::CMD_START &&
          op <= i2cm_pkg::CMD_READ) begin
        cmd      = i2cm_pkg::cmd_e'(op);
        phase_no = 0;
        tick_cnt = '0;
        if (cmd == i2cm_pkg::CMD_WRITE) shift_reg = wb;
        else if (cmd == i2cm_pkg::CMD_READ) begin
          shift_reg   = '0;
          ack_to_send = sa;
        end
        started[int'(cmd)]++;
        enter_phase(0);
      end
      r.scl_pull_low = scl_low;
      r.sda_pull_low = sda_low;
      if (cmd != i2cm_pkg::CMD_IDLE) begin
        total    = (cmd == i2cm_pkg::CMD_WRITE || cmd == i2cm_pkg::CMD_READ) ?
                   ByteCmdPhases : CondPhases;
        tick_cnt = tick_cnt + 16'd1;
        if (tick_cnt >= hp) begin
          // sample at the end of an SCL-high phase
          if (cmd == i2cm_pkg::CMD_WRITE && phase_no == AckSclHigh) begin
            ack_flag = ~lv;
            if (!lv) acks_seen++;
          end else if (cmd == i2cm_pkg::CMD_READ && phase_no < DataPhases &&
                       phase_no % 3 == 1) begin
            shift_reg[7 - phase_no / 3] = lv;
          end
          tick_cnt = '0;
          phase_no++;
          if (phase_no >= total) begin
            if (cmd == i2cm_pkg::CMD_READ) begin
              sda_low     = 1'b0;
              read_result = shift_reg;
            end
            cmd      = i2cm_pkg::CMD_IDLE;
            phase_no = 0;
            done     = 1'b1;
            completions++;
          end else begin
            enter_phase(phase_no);
          end
        end
      end
      r.busy_res     = (cmd != i2cm_pkg::CMD_IDLE);
      r.done_res     = done;
      r.ack_received = ack_flag;
      r.read_byte    = read_result;
      expected_q.push_back(r);
      ticks++;
    endfunction

    function void check_result(i2cm_pkg::res_t got);
      i2cm_pkg::res_t want;
      if (expected_q.size() == 0) begin
        $error("result item %h arrived with no tick outstanding", got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.scl_pull_low !== want.scl_pull_low) begin
        $error("scl_pull_low: expected %0b, got %0b", want.scl_pull_low, got.scl_pull_low);
        errors++;
      end
      if (got.sda_pull_low !== want.sda_pull_low) begin
        $error("sda_pull_low: expected %0b, got %0b", want.sda_pull_low, got.sda_pull_low);
        errors++;
      end
      if (got.busy_res !== want.busy_res) begin
        $error("busy_res: expected %0b, got %0b", want.busy_res, got.busy_res);
        errors++;
      end
      if (got.done_res !== want.done_res) begin
        $error("done_res: expected %0b, got %0b", want.done_res, got.done_res);
        errors++;
      end
      if (got.ack_received !== want.ack_received) begin
        $error("ack_received: expected %0b, got %0b", want.ack_received, got.ack_received);
        errors++;
      end
      if (got.read_byte !== want.read_byte) begin
        $error("read_byte: expected %h, got %h", want.read_byte, got.read_byte);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        cfg_we_i     = 1'b0;
  logic [15:0] cfg_wdata_i  = '0;
  logic        in_valid_i   = 1'b0;
  logic [2:0]  opcode_i     = i2cm_pkg::CMD_IDLE;
  logic [7:0]  write_byte_i = '0;
  logic        send_ack_i   = 1'b0;
  logic        sda_level_i  = 1'b1;
  logic        out_ready_i  = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic        scl_pull_low_o;
  logic        sda_pull_low_o;
  logic        busy_res_o;
  logic        done_res_o;
  logic        ack_received_o;
  logic [7:0]  read_byte_o;

  i2cm_pkg::res_t     got_w;
  i2c_tick_scoreboard sb;
  int                 n_items     = 0;
  bit                 calm        = 1'b0;
  bit                 rx_hold_req = 1'b0;

  assign got_w = {scl_pull_low_o, sda_pull_low_o, busy_res_o, done_res_o,
                  ack_received_o, read_byte_o};

  i2c_master_byte_engine_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .write_byte_i  (write_byte_i),
    .send_ack_i    (send_ack_i),
    .sda_level_i   (sda_level_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .scl_pull_low_o(scl_pull_low_o),
    .sda_pull_low_o(sda_pull_low_o),
    .busy_res_o    (busy_res_o),
    .done_res_o    (done_res_o),
    .ack_received_o(ack_received_o),
    .read_byte_o   (read_byte_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #800000;
    $error("run did not finish in time");
    $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(got_w);
  end

  // result side: short random stalls, plus one long hold-off on request
  initial begin : rx_side
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        hold_left   = 60;
        rx_hold_req = 1'b0;
      end
      if (!rst_ni) out_ready_i <= 1'b0;
      else if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        stall_left = int'($urandom_range(0, 3));
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // one tick item; valid is left high so back-to-back items need no drop
  task automatic push_tick(input logic [2:0] op, input logic [7:0] wb, input logic sa,
                           input logic lv);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    write_byte_i <= wb;
    send_ack_i   <= sa;
    sda_level_i  <= lv;
    do begin
      @(posedge clk_i);
    end while (in_ready_o !== 1'b1);
    sb.note_tick(op, wb, sa, lv);
    n_items++;
  endtask

  task automatic tick_while_busy(input int lv_mode, input logic [2:0] busy_op,
                                 input bit rand_busy);
    logic [2:0] op;
    logic       lv;
    while (sb.busy()) begin
      op = busy_op;
      if (rand_busy)
        op = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : i2cm_pkg::CMD_IDLE;
      lv = (lv_mode == LvRand) ? 1'($urandom_range(0, 1)) : (lv_mode == LvHigh);
      push_tick(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), lv);
    end
  endtask

  task automatic run_cmd(input logic [2:0] op, input logic [7:0] wb, input logic sa,
                         input int lv_mode, input logic [2:0] busy_op, input bit rand_busy);
    logic lv;
    lv = (lv_mode == LvRand) ? 1'($urandom_range(0, 1)) : (lv_mode == LvHigh);
    push_tick(op, wb, sa, lv);
    tick_while_busy(lv_mode, busy_op, rand_busy);
  endtask

  task automatic wait_results();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic update_half(input logic [15:0] v);
    wait_results();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_half(v);
  endtask

  task automatic random_transfer();
    int kind;
    kind = int'($urandom_range(0, 9));
    if (kind == 0) begin
      // noise on an idle bus, spare opcodes included
      repeat ($urandom_range(1, 3))
        push_tick(3'($urandom_range(i2cm_pkg::CMD_IDLE, OpSpareHi)),
                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      tick_while_busy(LvRand, i2cm_pkg::CMD_IDLE, 1'b1);
    end else if (kind == 1) begin
      // a lone command outside any framing
      run_cmd(3'($urandom_range(i2cm_pkg::CMD_START, i2cm_pkg::CMD_READ)),
              8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), LvRand,
              i2cm_pkg::CMD_IDLE, 1'b1);
    end else begin
      run_cmd(i2cm_pkg::CMD_START, 8'($urandom_range(0, 255)), 1'b0, LvRand,
              i2cm_pkg::CMD_IDLE, 1'b1);
      run_cmd(i2cm_pkg::CMD_WRITE, 8'($urandom_range(0, 255)), 1'b0, LvRand,
              i2cm_pkg::CMD_IDLE, 1'b1);
      repeat ($urandom_range(1, 3))
        run_cmd($urandom_range(0, 1) ? i2cm_pkg::CMD_WRITE : i2cm_pkg::CMD_READ,
                8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), LvRand,
                i2cm_pkg::CMD_IDLE, 1'b1);
      if ($urandom_range(0, 4) == 0)
        run_cmd(i2cm_pkg::CMD_START, 8'($urandom_range(0, 255)), 1'b0, LvRand,
                i2cm_pkg::CMD_IDLE, 1'b1);
      run_cmd(i2cm_pkg::CMD_STOP, 8'($urandom_range(0, 255)), 1'b0, LvRand,
              i2cm_pkg::CMD_IDLE, 1'b1);
    end
  endtask

  initial begin : main_seq
    logic [15:0] hp;
    int          next_cfg;
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset half period of 30, spare opcodes on the idle bus
    push_tick(i2cm_pkg::CMD_IDLE, 8'h00, 1'b0, 1'b0);
    push_tick(OpSpareLo, 8'hFF, 1'b1, 1'b1);
    push_tick(OpSpareHi, 8'h5A, 1'b0, 1'b1);
    run_cmd(i2cm_pkg::CMD_START, 8'h00, 1'b0, LvRand, i2cm_pkg::CMD_IDLE, 1'b0);

    // zero half period counts as one
    update_half(16'h0000);
    // commands during busy are dropped, the completing tick too
    run_cmd(i2cm_pkg::CMD_START, 8'h00, 1'b0, LvHigh, i2cm_pkg::CMD_STOP, 1'b0);
    run_cmd(i2cm_pkg::CMD_WRITE, 8'hFF, 1'b0, LvHigh, OpSpareLo, 1'b0);
    run_cmd(i2cm_pkg::CMD_WRITE, 8'h00, 1'b1, LvLow, i2cm_pkg::CMD_READ, 1'b0);
    run_cmd(i2cm_pkg::CMD_WRITE, 8'hA5, 1'b0, LvRand, i2cm_pkg::CMD_IDLE, 1'b0);
    run_cmd(i2cm_pkg::CMD_READ, 8'h00, 1'b1, LvHigh, i2cm_pkg::CMD_WRITE, 1'b0);
    run_cmd(i2cm_pkg::CMD_READ, 8'hFF, 1'b0, LvLow, i2cm_pkg::CMD_START, 1'b0);
    run_cmd(i2cm_pkg::CMD_READ, 8'h3C, 1'b1, LvRand, OpSpareHi, 1'b0);
    run_cmd(i2cm_pkg::CMD_STOP, 8'hC3, 1'b1, LvRand, i2cm_pkg::CMD_IDLE, 1'b0);

    // longest half period, then shortened while the phase is part way through
    update_half(16'hFFFF);
    push_tick(i2cm_pkg::CMD_START, 8'h00, 1'b0, 1'b1);
    repeat (20) push_tick(i2cm_pkg::CMD_IDLE, 8'h00, 1'b0, 1'b1);
    update_half(16'd3);
    tick_while_busy(LvRand, i2cm_pkg::CMD_IDLE, 1'b1);

    update_half(16'd4);
    push_tick(i2cm_pkg::CMD_WRITE, 8'h96, 1'b0, 1'b1);
    repeat (6) push_tick(i2cm_pkg::CMD_IDLE, 8'h00, 1'b0, 1'b1);
    update_half(16'd1);
    tick_while_busy(LvRand, i2cm_pkg::CMD_IDLE, 1'b1);

    // receiver holds off while items keep coming, so the input stalls
    calm        = 1'b1;
    rx_hold_req = 1'b1;
    repeat (16)
      push_tick(3'($urandom_range(i2cm_pkg::CMD_IDLE, OpSpareHi)),
                8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
    tick_while_busy(LvRand, i2cm_pkg::CMD_IDLE, 1'b1);
    calm = 1'b0;
    wait_results();

    next_cfg = n_items;
    while (n_items < TargetItems) begin
      if (n_items >= next_cfg) begin
        case ($urandom_range(0, 9))
          0:          hp = 16'd0;
          1, 2, 3, 4: hp = 16'd1;
          5, 6, 7:    hp = 16'd2;
          8:          hp = 16'd3;
          default:    hp = 16'($urandom_range(4, 8));
        endcase
        update_half(hp);
        next_cfg = n_items + 250;
      end
      if (n_items >= CalmFrom) calm = 1'b1;
      random_transfer();
    end

    wait_results();
    repeat (4) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $error("%0d expected result items never arrived", sb.pending());
      sb.errors++;
    end
    $display("Ran %0d ticks: %0d START, %0d STOP, %0d WRITE, %0d READ, %0d completed.",
             sb.ticks, sb.started[i2cm_pkg::CMD_START], sb.started[i2cm_pkg::CMD_STOP],
             sb.started[i2cm_pkg::CMD_WRITE], sb.started[i2cm_pkg::CMD_READ],
             sb.completions);
    $display("Half periods 0 to 8, 30 and 65535, two mid-command changes; %0d slave ACKs.",
             sb.acks_seen);
    if (sb.errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
